/* hw/rtl/lsb_stego_extractor_top_macros.svh */
// Assertion macros shared by the extractor's checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef LSB_STEGO_EXTRACTOR_TOP_MACROS_SVH
`define LSB_STEGO_EXTRACTOR_TOP_MACROS_SVH

// same-cycle implication
`define LSE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lse assertion failed");

// next-cycle implication
`define LSE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lse assertion failed");

`endif

/* hw/rtl/lse_pkg.sv */
// Types and constants for the LSB message extractor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package lse_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned HCNT_W = 8;
	localparam int unsigned BCNT_W = 5;
	localparam int unsigned LEFT_W = 31;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	// register word index, taken from paddr[2]
	localparam logic REG_PASSCODE = 1'b0;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_HEADER = 3'd1,
		PH_PASS = 3'd2,
		PH_LEN = 3'd3,
		PH_MSG = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_BAD_PASS = 2'd1,
		KIND_EARLY_END = 2'd2,
		KIND_EMPTY = 2'd3
	} kind_t;

	localparam logic [BCNT_W-1:0] LAST_WORD_BIT = 5'd31;
	localparam logic [BCNT_W-1:0] LAST_BYTE_BIT = 5'd7;

	typedef struct packed {
		logic lsb;
		logic start;
		logic ended;
	} item_t;

endpackage

/* hw/rtl/lse_apb_regs.sv */
// APB register file of the extractor: holds the expected passcode.
// Depends on lse_pkg.
`timescale 1ns / 1ps
module lse_apb_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lse_pkg::PADDR_W-1:0]   paddr,
	input  logic [lse_pkg::PDATA_W-1:0]   pwdata,
	output logic [lse_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [lse_pkg::WORD_W-1:0]    passcode
);
	import lse_pkg::*;

	logic [WORD_W-1:0] passcode_q;
	logic              wr_en;

	// word-addressed decode; low address bits are don't-care
	assign wr_en = psel && penable && pwrite && (paddr[2] == REG_PASSCODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			passcode_q <= '0;
		end else if (wr_en) begin
			passcode_q <= pwdata;
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_PASSCODE) begin
			prdata = passcode_q;
		end
	end

	assign pready = 1'b1;
	assign passcode = passcode_q;

endmodule

/* hw/rtl/lse_in_stage.sv */
// Input register stage of the extractor: captures one request per cycle while in_ready is high.
// Depends on lse_pkg.
`timescale 1ns / 1ps
module lse_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     file_byte,
	input  logic           file_start,
	input  logic           file_ended,
	input  logic           advance,
	output logic           valid_s1,
	output lse_pkg::item_t item_s1
);
	import lse_pkg::*;

	logic  vld_s1;
	item_t itm_s1;

	assign in_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	// only bit 0 of the byte carries data
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			itm_s1 <= '{lsb: file_byte[0], start: file_start, ended: file_ended};
		end
	end

	assign valid_s1 = vld_s1;
	assign item_s1 = itm_s1;

endmodule

/* hw/rtl/lse_decode.sv */
// Decode state and result register of the extractor: header skip, passcode,
// length and message gathering. Depends on lse_pkg.
`timescale 1ns / 1ps
module lse_decode #(
	parameter int unsigned HEADER_BYTES = 54
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid_s1,
	input  lse_pkg::item_t             item_s1,
	output logic                       advance,
	input  logic [lse_pkg::WORD_W-1:0] passcode,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 result_kind,
	output logic [7:0]                 message_byte,
	output logic                       last_byte
);
	import lse_pkg::*;

	localparam logic [HCNT_W-1:0] HDR_LEN = HCNT_W'(HEADER_BYTES);

	phase_t              phase_q, e_phase, phase_d;
	logic [HCNT_W-1:0]   hcnt_q, e_hcnt, hcnt_d;
	logic [BCNT_W-1:0]   bcnt_q, e_bcnt, bcnt_d;
	logic [LEFT_W-1:0]   left_q, e_left, left_d;
	logic [WORD_W-1:0]   gather_q, gather_d, shifted;
	logic                res_v, res_last;
	kind_t               res_kind;
	logic [7:0]          res_byte;
	logic                out_valid_q, last_q;
	kind_t               kind_q;
	logic [7:0]          byte_q;

	assign advance = valid_s1 && (!out_valid_q || out_ready);

	// bits enter at the top, so the first bit ends up lowest
	assign shifted = {item_s1.lsb, gather_q[WORD_W-1:1]};

	always_comb begin
		e_phase = phase_q;
		e_hcnt = hcnt_q;
		e_bcnt = bcnt_q;
		e_left = left_q;
		if (item_s1.start) begin
			e_hcnt = '0;
			e_bcnt = '0;
			e_left = '0;
			e_phase = (HDR_LEN != '0) ? PH_HEADER : PH_PASS;
		end

		phase_d = e_phase;
		hcnt_d = e_hcnt;
		bcnt_d = e_bcnt;
		left_d = e_left;
		gather_d = gather_q;
		res_v = 1'b0;
		res_kind = KIND_BYTE;
		res_byte = '0;
		res_last = 1'b0;

		case (e_phase)
			PH_HEADER, PH_PASS, PH_LEN, PH_MSG: begin
				if (item_s1.ended) begin
					phase_d = PH_IDLE;
					res_v = 1'b1;
					res_kind = KIND_EARLY_END;
				end else if (e_phase == PH_HEADER) begin
					hcnt_d = e_hcnt + 1'b1;
					if (hcnt_d >= HDR_LEN) begin
						phase_d = PH_PASS;
						bcnt_d = '0;
					end
				end else if (e_phase == PH_MSG) begin
					gather_d = shifted;
					if (e_bcnt != LAST_BYTE_BIT) begin
						bcnt_d = e_bcnt + 1'b1;
					end else begin
						bcnt_d = '0;
						res_v = 1'b1;
						res_byte = shifted[WORD_W-1 -: 8];
						res_last = (e_left <= LEFT_W'(1));
						left_d = e_left - 1'b1;
						phase_d = res_last ? PH_IDLE : PH_MSG;
					end
				end else begin
					gather_d = shifted;
					if (e_bcnt != LAST_WORD_BIT) begin
						bcnt_d = e_bcnt + 1'b1;
					end else begin
						bcnt_d = '0;
						if (e_phase == PH_PASS) begin
							if (shifted != passcode) begin
								phase_d = PH_IDLE;
								res_v = 1'b1;
								res_kind = KIND_BAD_PASS;
							end else begin
								phase_d = PH_LEN;
							end
						end else if (shifted == '0 || shifted[WORD_W-1]) begin
							// top bit set counts as an empty message
							phase_d = PH_IDLE;
							res_v = 1'b1;
							res_kind = KIND_EMPTY;
						end else begin
							left_d = shifted[LEFT_W-1:0];
							phase_d = PH_MSG;
						end
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hcnt_q <= '0;
			bcnt_q <= '0;
			left_q <= '0;
			gather_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q <= phase_d;
				hcnt_q <= hcnt_d;
				bcnt_q <= bcnt_d;
				left_q <= left_d;
				gather_q <= gather_d;
			end
			if (advance && res_v) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_v) begin
			kind_q <= res_kind;
			byte_q <= res_byte;
			last_q <= res_last;
		end
	end

	assign out_valid = out_valid_q;
	assign result_kind = kind_q;
	assign message_byte = byte_q;
	assign last_byte = last_q;

endmodule

/* hw/rtl/lsb_stego_extractor_top.sv */
// LSB message extractor: takes one image-file byte per cycle and, after a
// header of HEADER_BYTES bytes, gathers bit 0 of each byte into a 32-bit
// passcode, a 32-bit length and then message bytes (first bit lowest). It
// accepts a new request every cycle while in_ready is high; a request that
// yields a result reaches the output through the input register and then
// the result register. These are the only stages, so the input stalls only
// while a result is held waiting for out_ready and the input register is
// full. The passcode register sits at APB address 0.
`timescale 1ns / 1ps
module lsb_stego_extractor_top #(
	parameter int unsigned HEADER_BYTES = 54
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    file_byte,
	input  logic                          file_start,
	input  logic                          file_ended,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    result_kind,
	output logic [7:0]                    message_byte,
	output logic                          last_byte,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lse_pkg::PADDR_W-1:0]   paddr,
	input  logic [lse_pkg::PDATA_W-1:0]   pwdata,
	output logic [lse_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import lse_pkg::*;

	logic              advance;
	logic              valid_s1;
	item_t             item_s1;
	logic [WORD_W-1:0] passcode;

	lse_apb_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.passcode (passcode)
	);

	lse_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.file_byte  (file_byte),
		.file_start (file_start),
		.file_ended (file_ended),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	lse_decode #(
		.HEADER_BYTES (HEADER_BYTES)
	) u_dec (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1),
		.advance      (advance),
		.passcode     (passcode),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_kind  (result_kind),
		.message_byte (message_byte),
		.last_byte    (last_byte)
	);

endmodule

/* hw/rtl/lse_checker.sv */
// Port-level checker for the LSB message extractor, bound to the top level.
// Depends on lse_pkg and lsb_stego_extractor_top_macros.svh.
`timescale 1ns / 1ps
`include "lsb_stego_extractor_top_macros.svh"
module lse_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [1:0]                    result_kind,
	input logic [7:0]                    message_byte,
	input logic                          last_byte,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [lse_pkg::PADDR_W-1:0]   paddr,
	input logic [lse_pkg::PDATA_W-1:0]   pwdata,
	input logic [lse_pkg::PDATA_W-1:0]   prdata,
	input logic                          pready
);
	import lse_pkg::*;

	logic pass_wr;
	logic side_ok;

	assign pass_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PASSCODE);
	// status results carry no byte and no last flag; last only on bytes
	assign side_ok = (result_kind == KIND_BYTE) ||
		((message_byte == 8'h00) && !last_byte);

	`LSE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`LSE_ASSERT_NOW(a_side_fields, out_valid, side_ok)
	`LSE_ASSERT_NEXT(a_pass_readback, pass_wr && !(in_valid && in_ready),
		(paddr[2] != REG_PASSCODE) || (prdata == $past(pwdata)))
	`LSE_ASSERT_NOW(a_pready_high, 1'b1, pready)

endmodule

bind lsb_stego_extractor_top lse_checker u_lse_checker (.*);
